// ===== design/uslctd_pkg.sv =====
// uslctd_pkg: types and constants of the six-lobe uneven crank trigger decoder
// used by the channel interfaces and the decoder top level; no dependencies
`default_nettype none

package uslctd_pkg;

  typedef logic [31:0] stamp_t;
  typedef logic [2:0]  lobe_t;
  typedef logic [6:0]  angle_t;
  typedef logic [7:0]  loss_t;
  typedef logic [1:0]  flt_lvl_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_ACTIVE_LEVEL = 1'b0;
  localparam cfg_idx_t CFG_FILTER_LEVEL = 1'b1;

  localparam flt_lvl_t FLT_NONE    = 2'd0;
  localparam flt_lvl_t FLT_QUARTER = 2'd1;
  localparam flt_lvl_t FLT_HALF    = 2'd2;
  localparam flt_lvl_t FLT_3QUART  = 2'd3;

  localparam stamp_t FILTER_RESET = 32'd1500;
  localparam stamp_t FILTER_LIMIT = 32'd50000;

  // largest scaled gap whose quarter-level filter stays within the limit
  localparam logic [32:0] SCALED_MAX = 33'd200003;

  localparam angle_t ANGLE_WIDE   = 7'd70;
  localparam angle_t ANGLE_NARROW = 7'd40;

  localparam lobe_t LOBE_NONE = 3'd0;
  localparam lobe_t LOBE_SYNC = 3'd1;
  localparam lobe_t LOBE_2    = 3'd2;
  localparam lobe_t LOBE_4    = 3'd4;
  localparam lobe_t LOBE_5    = 3'd5;
  localparam lobe_t LOBE_LAST = 3'd6;

  // divide by 7 as multiply by ceil(2^24 / 7), exact for 21-bit numerators
  localparam int          RECIP7_SHIFT = 24;
  localparam logic [21:0] RECIP7       = 22'd2396746;

endpackage

`default_nettype wire

// ===== design/uslctd_if.sv =====
// uslctd channel interfaces: input edge, result and configuration write
// depends on uslctd_pkg
`default_nettype none

interface uslctd_in_if;
  logic                valid;
  logic                ready;
  logic                pin_level;
  uslctd_pkg::stamp_t  timestamp;

  modport source (output valid, output pin_level, output timestamp, input ready);
  modport sink   (input valid, input pin_level, input timestamp, output ready);
endinterface

interface uslctd_out_if;
  logic                valid;
  logic                ready;
  logic                has_sync;
  logic                valid_trigger;
  uslctd_pkg::lobe_t   lobe_count;
  uslctd_pkg::lobe_t   tooth_position;
  uslctd_pkg::angle_t  tooth_angle;
  uslctd_pkg::stamp_t  tooth_last_time;
  uslctd_pkg::stamp_t  tooth_prev_time;
  uslctd_pkg::stamp_t  tooth_one_time;
  uslctd_pkg::stamp_t  tooth_one_prev_time;
  logic                revolution_pulse;
  uslctd_pkg::loss_t   sync_loss_count;

  modport source (output valid, output has_sync, output valid_trigger, output lobe_count,
                  output tooth_position, output tooth_angle, output tooth_last_time,
                  output tooth_prev_time, output tooth_one_time,
                  output tooth_one_prev_time, output revolution_pulse,
                  output sync_loss_count, input ready);
  modport sink   (input valid, input has_sync, input valid_trigger, input lobe_count,
                  input tooth_position, input tooth_angle, input tooth_last_time,
                  input tooth_prev_time, input tooth_one_time,
                  input tooth_one_prev_time, input revolution_pulse,
                  input sync_loss_count, output ready);
endinterface

interface uslctd_cfg_if;
  logic                  valid;
  logic                  ready;
  uslctd_pkg::cfg_idx_t  index;
  uslctd_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/uneven_six_lobe_crank_trigger_decoder.sv =====
// uneven_six_lobe_crank_trigger_decoder: an input request reaches the result
// request through the input register, then the result register; one request per
// cycle sustained while the result channel is ready.
// rst_n is synchronous active low: filter time 1500, trigger valid set,
// active level 1, filter level 1, all other decoder state cleared, channels empty.
// depends on uslctd_pkg and the uslctd channel interfaces
`default_nettype none

module uneven_six_lobe_crank_trigger_decoder (
  input  wire logic     clk,
  input  wire logic     rst_n,
  uslctd_in_if.sink     in_ch,
  uslctd_out_if.source  out_ch,
  uslctd_cfg_if.sink    cfg_ch
);

  // configuration
  logic                  active_level_r;
  uslctd_pkg::flt_lvl_t  filter_level_r;

  // input register
  logic                  in_vld_r;
  logic                  pin_r;
  uslctd_pkg::stamp_t    ts_r;

  // decoder state
  uslctd_pkg::stamp_t    filter_time_r,   filter_time_nxt;
  uslctd_pkg::stamp_t    last_tooth_r,    last_tooth_nxt;
  uslctd_pkg::stamp_t    prev_tooth_r,    prev_tooth_nxt;
  uslctd_pkg::stamp_t    rise_r,          rise_nxt;
  uslctd_pkg::stamp_t    last_width_r,    last_width_nxt;
  uslctd_pkg::lobe_t     lobe_r,          lobe_nxt;
  uslctd_pkg::lobe_t     tooth_num_r,     tooth_num_nxt;
  uslctd_pkg::angle_t    angle_r,         angle_nxt;
  uslctd_pkg::stamp_t    sync_stamp_r,    sync_stamp_nxt;
  uslctd_pkg::stamp_t    prev_sync_r,     prev_sync_nxt;
  logic                  sync_flag_r,     sync_flag_nxt;
  logic                  valid_flag_r,    valid_flag_nxt;
  uslctd_pkg::loss_t     loss_r,          loss_nxt;
  logic                  pulse_nxt;

  // result register
  logic                  out_vld_r;
  logic                  o_sync_r;
  logic                  o_trig_r;
  uslctd_pkg::lobe_t     o_lobe_r;
  uslctd_pkg::lobe_t     o_tooth_r;
  uslctd_pkg::angle_t    o_angle_r;
  uslctd_pkg::stamp_t    o_last_r;
  uslctd_pkg::stamp_t    o_prev_r;
  uslctd_pkg::stamp_t    o_one_r;
  uslctd_pkg::stamp_t    o_one_prev_r;
  logic                  o_pulse_r;
  uslctd_pkg::loss_t     o_loss_r;

  logic                  advance;
  logic                  is_active;
  uslctd_pkg::stamp_t    gap;
  uslctd_pkg::stamp_t    width;
  logic                  wide_lobe;

  // filter scaling
  logic [34:0]           gap_x7;
  logic [32:0]           gap_74;
  logic [20:0]           div_num;
  logic [42:0]           div_prod;
  logic [18:0]           gap_47;
  logic                  scaled_big;
  logic [17:0]           scaled;
  logic [19:0]           scaled_x3;
  logic [17:0]           frac;
  uslctd_pkg::stamp_t    new_filter;

  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign is_active = (pin_r == active_level_r);
  assign gap       = ts_r - last_tooth_r;
  assign width     = ts_r - rise_r;
  assign wide_lobe = {1'b0, width} > {last_width_r, 1'b0};

  assign gap_x7   = {gap, 3'b000} - {3'b000, gap};
  assign gap_74   = gap_x7[34:2];
  assign div_num  = {gap[18:0], 2'b00};
  assign div_prod = {22'd0, div_num} * {21'd0, uslctd_pkg::RECIP7};
  assign gap_47   = div_prod[uslctd_pkg::RECIP7_SHIFT +: 19];

  always_comb begin
    unique case (lobe_r) inside
      uslctd_pkg::LOBE_SYNC, uslctd_pkg::LOBE_4: begin
        scaled_big = (|gap[31:19]) || ({14'd0, gap_47} > uslctd_pkg::SCALED_MAX);
        scaled     = gap_47[17:0];
      end
      uslctd_pkg::LOBE_2, uslctd_pkg::LOBE_5: begin
        scaled_big = gap_74 > uslctd_pkg::SCALED_MAX;
        scaled     = gap_74[17:0];
      end
      default: begin
        scaled_big = {1'b0, gap} > uslctd_pkg::SCALED_MAX;
        scaled     = gap[17:0];
      end
    endcase
  end

  assign scaled_x3 = {2'b00, scaled} + {1'b0, scaled, 1'b0};

  always_comb begin
    unique case (filter_level_r)
      uslctd_pkg::FLT_QUARTER: frac = {2'b00, scaled[17:2]};
      uslctd_pkg::FLT_HALF:    frac = {1'b0, scaled[17:1]};
      uslctd_pkg::FLT_3QUART:  frac = scaled_x3[19:2];
      default:                 frac = '0;
    endcase
  end

  always_comb begin
    if (scaled_big || ({14'd0, frac} > uslctd_pkg::FILTER_LIMIT)) begin
      new_filter = '0;
    end else begin
      new_filter = {14'd0, frac};
    end
  end

  always_comb begin
    filter_time_nxt = filter_time_r;
    last_tooth_nxt  = last_tooth_r;
    prev_tooth_nxt  = prev_tooth_r;
    rise_nxt        = rise_r;
    last_width_nxt  = last_width_r;
    lobe_nxt        = lobe_r;
    tooth_num_nxt   = tooth_num_r;
    angle_nxt       = angle_r;
    sync_stamp_nxt  = sync_stamp_r;
    prev_sync_nxt   = prev_sync_r;
    sync_flag_nxt   = sync_flag_r;
    valid_flag_nxt  = valid_flag_r;
    loss_nxt        = loss_r;
    pulse_nxt       = 1'b0;
    if (is_active) begin
      rise_nxt = ts_r;
      if (gap >= filter_time_r) begin
        valid_flag_nxt = 1'b1;
        if (lobe_r != uslctd_pkg::LOBE_NONE) begin
          tooth_num_nxt   = lobe_r;
          filter_time_nxt = new_filter;
          prev_tooth_nxt  = last_tooth_r;
          last_tooth_nxt  = ts_r;
          unique case (lobe_r) inside
            uslctd_pkg::LOBE_2, uslctd_pkg::LOBE_5: angle_nxt = uslctd_pkg::ANGLE_NARROW;
            default:                                angle_nxt = uslctd_pkg::ANGLE_WIDE;
          endcase
          if (lobe_r == uslctd_pkg::LOBE_SYNC) begin
            prev_sync_nxt  = sync_stamp_r;
            sync_stamp_nxt = ts_r;
            sync_flag_nxt  = 1'b1;
            pulse_nxt      = 1'b1;
          end
        end else begin
          filter_time_nxt = '0;
        end
      end else begin
        valid_flag_nxt = 1'b0;
      end
    end else if (valid_flag_r) begin
      if (wide_lobe) begin
        if (lobe_r == uslctd_pkg::LOBE_NONE || lobe_r == uslctd_pkg::LOBE_LAST) begin
          sync_flag_nxt = 1'b1;
        end else begin
          loss_nxt = loss_r + 8'd1;
        end
        lobe_nxt = uslctd_pkg::LOBE_SYNC;
      end else if (lobe_r == uslctd_pkg::LOBE_LAST) begin
        lobe_nxt = uslctd_pkg::LOBE_SYNC;
        loss_nxt = loss_r + 8'd1;
      end else begin
        lobe_nxt = lobe_r + 3'd1;
      end
      last_width_nxt = width;
    end else begin
      valid_flag_nxt = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= 1'b1;
      filter_level_r <= uslctd_pkg::FLT_QUARTER;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        uslctd_pkg::CFG_ACTIVE_LEVEL: active_level_r <= cfg_ch.data[0];
        uslctd_pkg::CFG_FILTER_LEVEL: filter_level_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pin_r <= in_ch.pin_level;
      ts_r  <= in_ch.timestamp;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_time_r <= uslctd_pkg::FILTER_RESET;
      last_tooth_r  <= '0;
      prev_tooth_r  <= '0;
      rise_r        <= '0;
      last_width_r  <= '0;
      lobe_r        <= uslctd_pkg::LOBE_NONE;
      tooth_num_r   <= '0;
      angle_r       <= '0;
      sync_stamp_r  <= '0;
      prev_sync_r   <= '0;
      sync_flag_r   <= 1'b0;
      valid_flag_r  <= 1'b1;
      loss_r        <= '0;
    end else if (advance) begin
      filter_time_r <= filter_time_nxt;
      last_tooth_r  <= last_tooth_nxt;
      prev_tooth_r  <= prev_tooth_nxt;
      rise_r        <= rise_nxt;
      last_width_r  <= last_width_nxt;
      lobe_r        <= lobe_nxt;
      tooth_num_r   <= tooth_num_nxt;
      angle_r       <= angle_nxt;
      sync_stamp_r  <= sync_stamp_nxt;
      prev_sync_r   <= prev_sync_nxt;
      sync_flag_r   <= sync_flag_nxt;
      valid_flag_r  <= valid_flag_nxt;
      loss_r        <= loss_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_sync_r     <= sync_flag_nxt;
      o_trig_r     <= valid_flag_nxt;
      o_lobe_r     <= lobe_nxt;
      o_tooth_r    <= tooth_num_nxt;
      o_angle_r    <= angle_nxt;
      o_last_r     <= last_tooth_nxt;
      o_prev_r     <= prev_tooth_nxt;
      o_one_r      <= sync_stamp_nxt;
      o_one_prev_r <= prev_sync_nxt;
      o_pulse_r    <= pulse_nxt;
      o_loss_r     <= loss_nxt;
    end
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.has_sync            = o_sync_r;
  assign out_ch.valid_trigger       = o_trig_r;
  assign out_ch.lobe_count          = o_lobe_r;
  assign out_ch.tooth_position      = o_tooth_r;
  assign out_ch.tooth_angle         = o_angle_r;
  assign out_ch.tooth_last_time     = o_last_r;
  assign out_ch.tooth_prev_time     = o_prev_r;
  assign out_ch.tooth_one_time      = o_one_r;
  assign out_ch.tooth_one_prev_time = o_one_prev_r;
  assign out_ch.revolution_pulse    = o_pulse_r;
  assign out_ch.sync_loss_count     = o_loss_r;

  a_filter_limit: assert property (@(posedge clk) disable iff (!rst_n)
    filter_time_r <= uslctd_pkg::FILTER_LIMIT)
    else $error("filter time above limit");

  a_lobe_range: assert property (@(posedge clk) disable iff (!rst_n)
    lobe_r <= uslctd_pkg::LOBE_LAST)
    else $error("lobe counter out of range");

  a_pulse_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && o_pulse_r) |->
      (o_sync_r && o_tooth_r == uslctd_pkg::LOBE_SYNC && o_last_r == o_one_r))
    else $error("revolution pulse without sync tooth");

  a_pulse_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pulse_nxt) |=> (sync_stamp_r == last_tooth_r && sync_flag_r))
    else $error("sync tooth stamp not recorded");

endmodule

`default_nettype wire
